FILE: rtl/mrsi_pkg.sv
// Package with shared types, constants and the arctangent table builder.
`timescale 1ns / 1ps
package mrsi_pkg;

	localparam int MAX_INTERVALS_DEF = 1024;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W = 5;
	localparam int DIV_W = 64;
	localparam logic [63:0] TWO_PI_Q40 = 64'd6908435304715;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam longint QUARTER_PI_Q30 = 64'sd843314857;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_DIV_OFF = 4'd2;
	localparam logic [3:0] OP_MID = 4'd3;
	localparam logic [3:0] OP_MOD_EST = 4'd4;
	localparam logic [3:0] OP_FOLD = 4'd5;
	localparam logic [3:0] OP_CORDIC = 4'd6;
	localparam logic [3:0] OP_DIV_SINC = 4'd7;
	localparam logic [3:0] OP_ACC = 4'd8;
	localparam logic [3:0] OP_ACC_ONE = 4'd9;
	localparam logic [3:0] OP_DIV_AVG = 4'd10;
	localparam logic [3:0] OP_MUL = 4'd11;
	localparam logic [3:0] OP_RES = 4'd12;
	localparam logic [3:0] OP_MOD_SUB = 4'd13;
	localparam logic [3:0] OP_MOD_FIX = 4'd14;

	typedef struct packed {
		logic [3:0] op;
	} mrsi_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mid_zero;
		logic idx_last;
		logic iter_last;
		logic out_free;
	} mrsi_sts_t;

	// Bitwise long division, used only while building constants.
	function automatic longint long_div(input longint num, input longint den);
		longint rem;
		longint quo;
		rem = 0;
		quo = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'sd1);
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'sd1;
			end
		end
		return quo;
	endfunction

	// Arctangent of 2^-i in Q.30 from a Q.60 series sum.
	function automatic longint atan_entry(input int i);
		longint acc;
		longint term;
		logic neg;
		int sh;
		acc = 0;
		neg = 1'b0;
		if (i == 0) begin
			return QUARTER_PI_Q30;
		end
		for (int k = 1; k <= 61; k += 2) begin
			sh = 60 - i * k;
			if (sh >= 0) begin
				term = long_div(64'sd1 << sh, longint'(k));
				acc = neg ? acc - term : acc + term;
				neg = !neg;
			end
		end
		return (acc + (64'sd1 <<< 29)) >>> 30;
	endfunction

endpackage

FILE: rtl/mrsi_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mrsi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mrsi_pkg::DIV_W-1:0]   dividend,
	input  logic [mrsi_pkg::DIV_W-1:0]   divisor,
	output logic [mrsi_pkg::DIV_W-1:0]   quotient,
	output logic                         done
);
	localparam int W = mrsi_pkg::DIV_W;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] trial;
	logic [W:0] diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

FILE: rtl/mrsi_datapath.sv
// Datapath: midpoints, angle reduction, CORDIC, accumulation and output register.
`timescale 1ns / 1ps
module mrsi_datapath #(
	parameter int MAX_INTERVALS = mrsi_pkg::MAX_INTERVALS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrsi_pkg::mrsi_cmd_t cmd,
	output mrsi_pkg::mrsi_sts_t sts,
	input  logic signed [31:0]  lower_limit,
	input  logic signed [31:0]  upper_limit,
	input  logic [10:0]         interval_count,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata
);
	localparam int NW = $clog2(MAX_INTERVALS + 1);
	localparam int SUMW = 32 + NW;
	localparam int SW = mrsi_pkg::STEP_W;
	localparam logic [42:0] MOD_C = 43'(mrsi_pkg::TWO_PI_Q40);
	localparam logic [11:0] MOD_RECIP = 12'((64'd1 << 54) / mrsi_pkg::TWO_PI_Q40);

	logic signed [31:0] a_q;
	logic [32:0] dmag_q;
	logic dneg_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] i_q;
	logic [63:0] num_q;
	logic [43:0] mmag_q;
	logic [11:0] mod_est_q;
	logic [44:0] mod_red_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [34:0] z_q;
	logic [SW-1:0] k_q;
	logic signed [SUMW-1:0] sum_q;
	logic [63:0] prod_q;
	logic [31:0] out_q;
	logic out_valid_q;

	logic [31:0] atan_tab [mrsi_pkg::CORDIC_STEPS];
	genvar g;
	for (g = 0; g < mrsi_pkg::CORDIC_STEPS; g++) begin : g_atan
		localparam longint AT = mrsi_pkg::atan_entry(g);
		assign atan_tab[g] = AT[31:0];
	end

	logic div_start;
	logic [63:0] dvd;
	logic [63:0] dvs;
	logic [63:0] div_q;
	logic div_done;

	logic [31:0] cnt32;
	logic signed [32:0] diff;
	logic signed [44:0] base;
	logic signed [44:0] off;
	logic signed [44:0] mid;
	logic [43:0] est_prod;
	logic [54:0] sub_prod;
	logic signed [34:0] z0;
	logic signed [34:0] z1;
	logic signed [34:0] zf;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [34:0] at;
	logic [33:0] sm;
	logic [30:0] qc;
	logic signed [31:0] sinc;
	logic [SUMW-1:0] smag;
	logic [41:0] res;
	logic rneg;
	logic [31:0] res_val;
	logic out_free;

	assign cnt32 = 32'(interval_count);
	assign diff = 33'(upper_limit) - 33'(lower_limit);
	assign base = 45'(a_q) <<< 10;
	assign off = 45'(div_q[43:0]);
	assign mid = dneg_q ? base - off : base + off;
	// The quotient estimate falls short of the true quotient by at most one.
	assign est_prod = 44'(mmag_q[43:12]) * 44'(MOD_RECIP);
	assign sub_prod = 55'(mod_est_q) * 55'(MOD_C);
	assign z0 = 35'((mod_red_q + 45'd512) >> 10);
	assign z1 = (z0 > mrsi_pkg::PI_Q30) ? z0 - mrsi_pkg::TWO_PI_Q30 : z0;
	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign at = 35'(atan_tab[k_q]);
	assign sm = y_q[33] ? 34'(-y_q) : 34'(y_q);
	assign qc = (div_q > 64'd1073741824) ? 31'd1073741824 : div_q[30:0];
	assign sinc = y_q[33] ? -32'(qc) : 32'(qc);
	assign smag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign res = 42'((prod_q + 64'd2097152) >> 22);
	assign rneg = (sum_q[SUMW-1] != dneg_q) && (res != '0);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		if (z1 > mrsi_pkg::HALF_PI_Q30) begin
			zf = mrsi_pkg::PI_Q30 - z1;
		end else if (z1 < -mrsi_pkg::HALF_PI_Q30) begin
			zf = -mrsi_pkg::PI_Q30 - z1;
		end else begin
			zf = z1;
		end
	end

	always_comb begin
		if (rneg) begin
			res_val = (res > 42'h80000000) ? 32'h80000000 : 32'(-res);
		end else begin
			res_val = (res > 42'h7FFFFFFF) ? 32'h7FFFFFFF : res[31:0];
		end
	end

	always_comb begin
		div_start = 1'b0;
		dvd = '0;
		dvs = '0;
		unique case (cmd.op)
			mrsi_pkg::OP_DIV_OFF: begin
				div_start = 1'b1;
				dvd = num_q;
				dvs = 64'({n_q, 1'b0});
			end
			mrsi_pkg::OP_DIV_SINC: begin
				div_start = 1'b1;
				dvd = 64'(sm) << 30;
				dvs = 64'(mmag_q);
			end
			mrsi_pkg::OP_DIV_AVG: begin
				div_start = 1'b1;
				dvd = 64'(smag);
				dvs = 64'(n_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mrsi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dvd),
		.divisor(dvs),
		.quotient(div_q),
		.done(div_done)
	);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mrsi_pkg::OP_LOAD: begin
				a_q <= lower_limit;
				dneg_q <= diff[32];
				dmag_q <= diff[32] ? 33'(-diff) : 33'(diff);
				num_q <= 64'(diff[32] ? 33'(-diff) : 33'(diff)) << 10;
				sum_q <= '0;
				if (cnt32 == 32'd0) begin
					n_q <= NW'(1);
				end else if (cnt32 > 32'(MAX_INTERVALS)) begin
					n_q <= NW'(MAX_INTERVALS);
				end else begin
					n_q <= NW'(cnt32);
				end
			end
			mrsi_pkg::OP_MID: begin
				mmag_q <= mid[44] ? 44'(-mid) : 44'(mid);
			end
			mrsi_pkg::OP_MOD_EST: begin
				mod_est_q <= est_prod[43:32];
			end
			mrsi_pkg::OP_MOD_SUB: begin
				mod_red_q <= 45'(55'({mmag_q, 10'b0}) - sub_prod);
			end
			mrsi_pkg::OP_MOD_FIX: begin
				if (mod_red_q >= 45'(MOD_C)) begin
					mod_red_q <= mod_red_q - 45'(MOD_C);
				end
			end
			mrsi_pkg::OP_FOLD: begin
				x_q <= mrsi_pkg::CORDIC_GAIN_Q30;
				y_q <= '0;
				z_q <= zf;
				k_q <= '0;
			end
			mrsi_pkg::OP_CORDIC: begin
				if (!z_q[34]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				k_q <= k_q + 1'b1;
			end
			mrsi_pkg::OP_ACC: begin
				sum_q <= sum_q + SUMW'(sinc);
				num_q <= num_q + (64'(dmag_q) << 11);
			end
			mrsi_pkg::OP_ACC_ONE: begin
				sum_q <= sum_q + SUMW'(32'sd1073741824);
				num_q <= num_q + (64'(dmag_q) << 11);
			end
			mrsi_pkg::OP_MUL: begin
				prod_q <= 64'(dmag_q) * 64'(div_q[30:0]);
			end
			mrsi_pkg::OP_RES: begin
				out_q <= res_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == mrsi_pkg::OP_LOAD) begin
				i_q <= '0;
			end else if (cmd.op == mrsi_pkg::OP_ACC || cmd.op == mrsi_pkg::OP_ACC_ONE) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.op == mrsi_pkg::OP_RES) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.mid_zero = (mmag_q == '0);
	assign sts.idx_last = (i_q == n_q - 1'b1);
	assign sts.iter_last = (k_q == SW'(mrsi_pkg::CORDIC_STEPS - 1));
	assign sts.out_free = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mrsi_pkg::OP_RES |-> out_free)
		else $error("result written while output word still pending");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_done)
		else $error("divider reports done right after a start");
	a_load_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mrsi_pkg::OP_LOAD |=> i_q == '0)
		else $error("midpoint index not cleared on load");

endmodule

FILE: rtl/mrsi_ctrl.sv
// Controller state machine sequencing the datapath for one input word.
`timescale 1ns / 1ps
module mrsi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  mrsi_pkg::mrsi_sts_t sts,
	output mrsi_pkg::mrsi_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OFF = 4'd1;
	localparam logic [3:0] S_OFF_W = 4'd2;
	localparam logic [3:0] S_MID = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_MOD_SUB = 4'd5;
	localparam logic [3:0] S_FOLD = 4'd6;
	localparam logic [3:0] S_COR = 4'd7;
	localparam logic [3:0] S_SINC = 4'd8;
	localparam logic [3:0] S_SINC_W = 4'd9;
	localparam logic [3:0] S_ACC = 4'd10;
	localparam logic [3:0] S_AVG = 4'd11;
	localparam logic [3:0] S_AVG_W = 4'd12;
	localparam logic [3:0] S_MUL = 4'd13;
	localparam logic [3:0] S_RES = 4'd14;
	localparam logic [3:0] S_MOD_FIX = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = mrsi_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op = mrsi_pkg::OP_LOAD;
					state_d = S_OFF;
				end
			end
			S_OFF: begin
				cmd.op = mrsi_pkg::OP_DIV_OFF;
				state_d = S_OFF_W;
			end
			S_OFF_W: begin
				if (sts.div_done) begin
					state_d = S_MID;
				end
			end
			S_MID: begin
				cmd.op = mrsi_pkg::OP_MID;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.mid_zero) begin
					cmd.op = mrsi_pkg::OP_ACC_ONE;
					state_d = sts.idx_last ? S_AVG : S_OFF;
				end else begin
					cmd.op = mrsi_pkg::OP_MOD_EST;
					state_d = S_MOD_SUB;
				end
			end
			S_MOD_SUB: begin
				cmd.op = mrsi_pkg::OP_MOD_SUB;
				state_d = S_MOD_FIX;
			end
			S_MOD_FIX: begin
				cmd.op = mrsi_pkg::OP_MOD_FIX;
				state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.op = mrsi_pkg::OP_FOLD;
				state_d = S_COR;
			end
			S_COR: begin
				cmd.op = mrsi_pkg::OP_CORDIC;
				if (sts.iter_last) begin
					state_d = S_SINC;
				end
			end
			S_SINC: begin
				cmd.op = mrsi_pkg::OP_DIV_SINC;
				state_d = S_SINC_W;
			end
			S_SINC_W: begin
				if (sts.div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.op = mrsi_pkg::OP_ACC;
				state_d = sts.idx_last ? S_AVG : S_OFF;
			end
			S_AVG: begin
				cmd.op = mrsi_pkg::OP_DIV_AVG;
				state_d = S_AVG_W;
			end
			S_AVG_W: begin
				if (sts.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op = mrsi_pkg::OP_MUL;
				state_d = S_RES;
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.op = mrsi_pkg::OP_RES;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OFF || state_q == S_SINC || state_q == S_AVG) |=> !sts.div_done)
		else $error("divider done seen before its result could be ready");
	a_cor_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COR && !sts.iter_last |=> state_q == S_COR)
		else $error("CORDIC left before its last step");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_OFF)
		else $error("accepted word did not start a run");

endmodule

FILE: rtl/midpoint_rule_sinc_integrator.sv
// Top level of the midpoint-rule sinc integrator.
`timescale 1ns / 1ps
// Takes a word with limits a, b (Q12.20) and a count n (0 counts as 1, values above
// MAX_INTERVALS are clamped) and returns the midpoint-rule integral of sin(x)/x over
// [a, b] in Q4.28, saturated. One word is worked on at a time; each midpoint takes two
// divides on the shared bit-serial 64-bit divider, a reduction modulo 2*pi (estimate,
// subtract, fix) and 30 CORDIC steps; a midpoint that lies exactly on zero skips the
// reduction, the CORDIC steps and the second divide. The run then waits for the output
// register to be free before writing the result. A finished result waits in the output
// register while the next word is accepted.
module midpoint_rule_sinc_integrator #(
	parameter int MAX_INTERVALS = mrsi_pkg::MAX_INTERVALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata, // lower_limit[31:0], upper_limit[63:32], interval_count[74:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata  // integral_value[31:0]
);
	mrsi_pkg::mrsi_cmd_t cmd;
	mrsi_pkg::mrsi_sts_t sts;

	mrsi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	mrsi_datapath #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.lower_limit(s_tdata[31:0]),
		.upper_limit(s_tdata[63:32]),
		.interval_count(s_tdata[74:64]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
